/* design/dnd_pkg.sv */
package dnd_pkg;

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned BCD_STEPS  = 8;
  localparam int unsigned BCD_STAGES = NUM_W / BCD_STEPS;

  localparam logic [3:0] CODE_B_BLANK = 4'hF;
  localparam logic [3:0] RAW_BLANK    = 4'h0;

  typedef enum logic [1:0] {
    CFG_DIGIT_COUNT = 2'd0,
    CFG_DECODE_EN   = 2'd1,
    CFG_CHAIN_LEN   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] number_value;
    logic [7:0]  point_mask;
    logic        suppress_leading;
    logic [2:0]  target_device;
  } in_t;

  typedef struct packed {
    logic [2:0] device_index;
    logic [3:0] digit_register;
    logic [7:0] segment_data;
    logic       bad_device;
    logic       last_write;
  } out_t;

  typedef struct packed {
    logic [7:0] point_mask;
    logic       suppress_leading;
    logic [2:0] target_device;
  } meta_t;

  typedef struct packed {
    logic [3:0] digit_count;
    logic [7:0] decode_en;
    logic [3:0] chain_length;
  } cfg_t;

endpackage

/* design/dnd_bcd_stage.sv */
module dnd_bcd_stage #(
  parameter int unsigned NumPos = 8,
  parameter int unsigned Steps  = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [4*NumPos-1:0]      bcd_i,
  input  logic [dnd_pkg::NUM_W-1:0] bin_i,
  input  dnd_pkg::meta_t           meta_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [4*NumPos-1:0]      bcd_o,
  output logic [dnd_pkg::NUM_W-1:0] bin_o,
  output dnd_pkg::meta_t           meta_o
);

  localparam int unsigned BcdW = 4 * NumPos;
  localparam int unsigned NumW = dnd_pkg::NUM_W;

  logic                valid_q;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [NumW-1:0]     bin_q, bin_d;
  dnd_pkg::meta_t      meta_q;
  logic                load;

  // shift-add-3 steps; carries out of the top digit drop (mod 10^NumPos)
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < Steps; s++) begin
      for (int d = 0; d < NumPos; d++) begin
        if (bcd_d[4*d +: 4] >= 4'd5) begin
          bcd_d[4*d +: 4] = bcd_d[4*d +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BcdW-2:0], bin_d[NumW-1]};
      bin_d = {bin_d[NumW-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q  <= bcd_d;
      bin_q  <= bin_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;
  assign meta_o  = meta_q;

endmodule

/* design/dnd_format.sv */
module dnd_format #(
  parameter int unsigned NumPos = 8,
  parameter int unsigned MaxDev = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [4*NumPos-1:0] bcd_i,
  input  dnd_pkg::meta_t      meta_i,
  input  dnd_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic                bad_o,
  output logic [2:0]          dev_o,
  output logic [3:0]          cnt_o,
  output logic [7:0]          seg_o [NumPos]
);

  localparam logic [3:0] MaxPosW = 4'(NumPos);
  localparam logic [4:0] MaxDevW = 5'(MaxDev);

  logic              valid_q;
  logic              bad_q, bad_d;
  logic [2:0]        dev_q;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        seg_q [NumPos];
  logic [7:0]        seg_d [NumPos];
  logic [4:0]        chain_eff;
  logic [NumPos-1:0] live;
  logic [NumPos-1:0] blank;
  logic              load;

  always_comb begin
    if (cfg_i.digit_count == 4'd0) begin
      cnt_d = 4'd1;
    end else if (cfg_i.digit_count > MaxPosW) begin
      cnt_d = MaxPosW;
    end else begin
      cnt_d = cfg_i.digit_count;
    end
    chain_eff = ({1'b0, cfg_i.chain_length} > MaxDevW) ? MaxDevW : {1'b0, cfg_i.chain_length};
    bad_d     = {2'b00, meta_i.target_device} >= chain_eff;
  end

  // live: active, non-zero; suppress_leading blanks p>0 when none live at or above
  always_comb begin
    for (int p = 0; p < NumPos; p++) begin
      live[p] = (4'(p) < cnt_d) && (bcd_i[4*p +: 4] != 4'd0);
    end
    for (int p = 0; p < NumPos; p++) begin
      blank[p] = meta_i.suppress_leading && (p != 0) && ((live >> p) == '0);
    end
    for (int p = 0; p < NumPos; p++) begin
      if (blank[p]) begin
        seg_d[p] = {meta_i.point_mask[p], 3'b000,
                    cfg_i.decode_en[p] ? dnd_pkg::CODE_B_BLANK : dnd_pkg::RAW_BLANK};
      end else begin
        seg_d[p] = {meta_i.point_mask[p], 3'b000, bcd_i[4*p +: 4]};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bad_q <= bad_d;
      dev_q <= meta_i.target_device;
      cnt_q <= cnt_d;
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign bad_o   = bad_q;
  assign dev_o   = dev_q;
  assign cnt_o   = cnt_q;
  assign seg_o   = seg_q;

endmodule

/* design/dnd_serial.sv */
module dnd_serial #(
  parameter int unsigned NumPos = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic          bad_i,
  input  logic [2:0]    dev_i,
  input  logic [3:0]    cnt_i,
  input  logic [7:0]    seg_i [NumPos],
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dnd_pkg::out_t out_data_o
);

  localparam int unsigned PosW = (NumPos > 1) ? $clog2(NumPos) : 1;

  logic            hold_q;
  logic [PosW-1:0] pos_q;
  logic            bad_q;
  logic [2:0]      dev_q;
  logic [3:0]      cnt_q;
  logic [7:0]      seg_q [NumPos];
  logic [3:0]      reg_addr;
  logic            last;
  logic            take;
  logic            load;

  assign reg_addr = 4'(pos_q) + 4'd1;
  assign last     = bad_q || (reg_addr == cnt_q);
  assign take     = hold_q && out_ready_i;
  assign ready_o  = !hold_q || (out_ready_i && last);
  assign load     = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      hold_q <= 1'b1;
      pos_q  <= '0;
    end else if (take) begin
      if (last) begin
        hold_q <= 1'b0;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bad_q <= bad_i;
      dev_q <= dev_i;
      cnt_q <= cnt_i;
      seg_q <= seg_i;
    end
  end

  always_comb begin
    out_data_o.device_index   = dev_q;
    out_data_o.digit_register = bad_q ? 4'd0 : reg_addr;
    out_data_o.segment_data   = bad_q ? 8'd0 : seg_q[pos_q];
    out_data_o.bad_device     = bad_q;
    out_data_o.last_write     = last;
  end

  assign out_valid_o = hold_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q && !bad_q |-> (4'(pos_q) < cnt_q))
    else $error("digit position past active count");

  a_stall_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q && !out_ready_i |=> hold_q && $stable(pos_q))
    else $error("position moved while output stalled");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> hold_q && (pos_q == '0))
    else $error("new transaction did not restart at position zero");

  a_cnt_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (cnt_i >= 4'd1) && (cnt_i <= 4'(NumPos)))
    else $error("digit count outside clamp range");

endmodule

/* design/decimal_number_to_digit_writes.sv */
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o   in_data_i  (dnd_pkg::in_t)
// out       out  out_valid_o/out_ready_i out_data_o (dnd_pkg::out_t)
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction in and one result out per cycle while nothing stalls; a number makes one
// write per active digit (one for a bad device), so the output port sets the rate.
// The first result is registered through 4 BCD stages, the format stage and the output hold.
// Reset empties the pipeline; count 8, decode mask 0, chain length 1.
// Output stalls propagate back stage by stage; nothing is dropped or repeated.
module decimal_number_to_digit_writes #(
  parameter int unsigned MAX_POSITIONS = 8,
  parameter int unsigned MAX_DEVICES   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dnd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dnd_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int unsigned Stages = dnd_pkg::BCD_STAGES;
  localparam int unsigned BcdW   = 4 * MAX_POSITIONS;

  dnd_pkg::cfg_t cfg_q;

  logic                      valid_s [Stages+1];
  logic                      ready_s [Stages+1];
  logic [BcdW-1:0]           bcd_s   [Stages+1];
  logic [dnd_pkg::NUM_W-1:0] bin_s   [Stages+1];
  dnd_pkg::meta_t            meta_s  [Stages+1];

  logic       fmt_valid, fmt_ready, fmt_bad;
  logic [2:0] fmt_dev;
  logic [3:0] fmt_cnt;
  logic [7:0] fmt_seg [MAX_POSITIONS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_count  <= 4'd8;
      cfg_q.decode_en    <= 8'd0;
      cfg_q.chain_length <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dnd_pkg::cfg_reg_e'(cfg_index_i))
        dnd_pkg::CFG_DIGIT_COUNT: cfg_q.digit_count  <= cfg_data_i[3:0];
        dnd_pkg::CFG_DECODE_EN:   cfg_q.decode_en    <= cfg_data_i;
        dnd_pkg::CFG_CHAIN_LEN:   cfg_q.chain_length <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign valid_s[0]                  = in_valid_i;
  assign in_ready_o                  = ready_s[0];
  assign bcd_s[0]                    = '0;
  assign bin_s[0]                    = in_data_i.number_value;
  assign meta_s[0].point_mask        = in_data_i.point_mask;
  assign meta_s[0].suppress_leading  = in_data_i.suppress_leading;
  assign meta_s[0].target_device     = in_data_i.target_device;

  for (genvar k = 0; k < Stages; k++) begin : g_bcd
    dnd_bcd_stage #(
      .NumPos (MAX_POSITIONS),
      .Steps  (dnd_pkg::BCD_STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .bcd_i   (bcd_s[k]),
      .bin_i   (bin_s[k]),
      .meta_i  (meta_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .bcd_o   (bcd_s[k+1]),
      .bin_o   (bin_s[k+1]),
      .meta_o  (meta_s[k+1])
    );
  end

  dnd_format #(
    .NumPos (MAX_POSITIONS),
    .MaxDev (MAX_DEVICES)
  ) u_format (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[Stages]),
    .ready_o (ready_s[Stages]),
    .bcd_i   (bcd_s[Stages]),
    .meta_i  (meta_s[Stages]),
    .cfg_i   (cfg_q),
    .valid_o (fmt_valid),
    .ready_i (fmt_ready),
    .bad_o   (fmt_bad),
    .dev_o   (fmt_dev),
    .cnt_o   (fmt_cnt),
    .seg_o   (fmt_seg)
  );

  dnd_serial #(
    .NumPos (MAX_POSITIONS)
  ) u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fmt_valid),
    .ready_o     (fmt_ready),
    .bad_i       (fmt_bad),
    .dev_i       (fmt_dev),
    .cnt_i       (fmt_cnt),
    .seg_i       (fmt_seg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
